/* hdl/hkf_pkg.sv */
package hkf_pkg;

   localparam int unsigned WORD_WIDTH  = 32;
   localparam int unsigned VALUE_WIDTH = 2 * WORD_WIDTH;
   localparam int unsigned NIB_WIDTH   = 4;
   localparam int unsigned COUNT_WIDTH = 5;
   localparam int unsigned KEY_LEN     = 16;
   localparam int unsigned COUNT_SAT   = 17;
   localparam int unsigned ROUNDS      = 4;
   localparam int unsigned ROUND_WIDTH = $clog2(ROUNDS);

   localparam logic [WORD_WIDTH-1:0] MIX_MUL = 32'h045D_9F3B;

   // register reset values
   localparam logic [WORD_WIDTH-1:0] ROUND_KEY_ONE_RESET   = 32'h5A3C_E7F1;
   localparam logic [WORD_WIDTH-1:0] ROUND_KEY_TWO_RESET   = 32'h1F4B_8C2D;
   localparam logic [WORD_WIDTH-1:0] ROUND_KEY_THREE_RESET = 32'hDEAD_1337;
   localparam logic [WORD_WIDTH-1:0] ROUND_KEY_FOUR_RESET  = 32'h8BAD_F00D;
   localparam logic [WORD_WIDTH-1:0] MATCH_HIGH_RESET      = 32'hA11C_3514;
   localparam logic [WORD_WIDTH-1:0] MATCH_LOW_RESET       = 32'hF00D_CAFE;

   // register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROUND_KEY_ONE   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROUND_KEY_TWO   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROUND_KEY_THREE = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROUND_KEY_FOUR  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATCH_HIGH      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATCH_LOW       = 3'd5;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic                  granted;
      logic                  well_formed;
      logic [WORD_WIDTH-1:0] cipher_high;
      logic [WORD_WIDTH-1:0] cipher_low;
   } rsp_type;

   // one finished string, handed from front to back
   typedef struct packed {
      logic [WORD_WIDTH-1:0] high_half;
      logic [WORD_WIDTH-1:0] low_half;
      logic                  well_formed;
   } job_type;

   typedef struct packed {
      logic [ROUNDS-1:0][WORD_WIDTH-1:0] round_key;
      logic [WORD_WIDTH-1:0]             match_high;
      logic [WORD_WIDTH-1:0]             match_low;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_flags_type;

   // bit 4 set: not a hex digit
   function automatic logic [NIB_WIDTH:0] hex_nibble(input logic [7:0] c);
      logic [NIB_WIDTH:0] nib;
      nib = 5'd16;
      if (c >= 8'h30 && c <= 8'h39) begin
         nib = {1'b0, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         nib = {1'b0, c[3:0] + 4'd9};
      end
      return nib;
   endfunction

   function automatic logic [WORD_WIDTH-1:0] xor_shift(input logic [WORD_WIDTH-1:0] x);
      return x ^ {16'b0, x[WORD_WIDTH-1:16]};
   endfunction

endpackage

/* hdl/hkf_front.sv */
module hkf_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  hkf_pkg::req_type        req_payload,
   input  hkf_pkg::fifo_flags_type q_flags,
   output logic                    q_push,
   output hkf_pkg::job_type        q_job
);

   logic [hkf_pkg::COUNT_WIDTH-1:0] count_ff, count_in, count_next;
   logic [hkf_pkg::VALUE_WIDTH-1:0] value_ff, value_in, value_next;
   logic                            bad_ff, bad_in, bad_next;
   logic [hkf_pkg::NIB_WIDTH:0]     nib;
   logic                            accept;

   assign req_stall = q_flags.full;
   assign accept    = req_valid && !q_flags.full;

   assign nib        = hkf_pkg::hex_nibble(req_payload.char_code);
   assign bad_next   = bad_ff || nib[hkf_pkg::NIB_WIDTH];
   assign value_next = {value_ff[hkf_pkg::VALUE_WIDTH-hkf_pkg::NIB_WIDTH-1:0],
                        nib[hkf_pkg::NIB_WIDTH] ? 4'h0 : nib[hkf_pkg::NIB_WIDTH-1:0]};
   assign count_next = (count_ff < hkf_pkg::COUNT_WIDTH'(hkf_pkg::COUNT_SAT)) ?
                       count_ff + 1'b1 : count_ff;

   assign q_push            = accept && req_payload.last_char;
   assign q_job.high_half   = value_next[hkf_pkg::VALUE_WIDTH-1:hkf_pkg::WORD_WIDTH];
   assign q_job.low_half    = value_next[hkf_pkg::WORD_WIDTH-1:0];
   assign q_job.well_formed = (count_next == hkf_pkg::COUNT_WIDTH'(hkf_pkg::KEY_LEN)) &&
                              !bad_next;

   always_comb begin
      count_in = count_ff;
      value_in = value_ff;
      bad_in   = bad_ff;
      if (accept) begin
         if (req_payload.last_char) begin
            count_in = '0;
            value_in = '0;
            bad_in   = 1'b0;
         end else begin
            count_in = count_next;
            value_in = value_next;
            bad_in   = bad_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         value_ff <= '0;
         bad_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         value_ff <= value_in;
         bad_ff   <= bad_in;
      end
   end

endmodule

/* hdl/hkf_queue.sv */
module hkf_queue #(
   parameter int unsigned DEPTH = hkf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  hkf_pkg::job_type        push_data,
   input  logic                    pop,
   output hkf_pkg::job_type        pop_data,
   output hkf_pkg::fifo_flags_type flags
);

   localparam int unsigned PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);

   hkf_pkg::job_type       entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   fill_ff, fill_in;

   assign flags.full  = (fill_ff == CNT_WIDTH'(DEPTH));
   assign flags.empty = (fill_ff == '0);
   assign pop_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> !flags.full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !flags.empty)
      else $error("queue pop while empty");

endmodule

/* hdl/hkf_back.sv */
module hkf_back (
   input  logic                    clock,
   input  logic                    reset,
   input  hkf_pkg::cfg_type        cfg,
   input  hkf_pkg::fifo_flags_type q_flags,
   input  hkf_pkg::job_type        q_job,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output hkf_pkg::rsp_type        rsp_payload
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL1 = 5'b00010,
      S_MUL2 = 5'b00100,
      S_MIX  = 5'b01000,
      S_HOLD = 5'b10000
   } state_type;

   localparam logic [hkf_pkg::ROUND_WIDTH-1:0] LAST_ROUND =
      hkf_pkg::ROUND_WIDTH'(hkf_pkg::ROUNDS - 1);

   state_type                          state_ff, state_in;
   logic [hkf_pkg::ROUND_WIDTH-1:0]    round_ff, round_in;
   logic [hkf_pkg::WORD_WIDTH-1:0]     l_ff, l_in, r_ff, r_in, prod_ff, prod_in;
   logic [hkf_pkg::WORD_WIDTH-1:0]     mul_src, mix_out;
   logic                               formed_ff, formed_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   hkf_pkg::rsp_type                   rsp_ff, rsp_in;
   logic                               out_free, load_rsp;

   // one shared 32x32 multiplier, low word kept
   assign mul_src = (state_ff == S_MUL1) ?
                    hkf_pkg::xor_shift(r_ff ^ cfg.round_key[round_ff]) :
                    hkf_pkg::xor_shift(prod_ff);
   assign mix_out = hkf_pkg::xor_shift(prod_ff);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_rsp = (state_ff == S_HOLD) && out_free;
   assign q_pop    = (state_ff == S_IDLE) && !q_flags.empty;

   always_comb begin
      state_in  = state_ff;
      round_in  = round_ff;
      l_in      = l_ff;
      r_in      = r_ff;
      prod_in   = prod_ff;
      formed_in = formed_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_flags.empty) begin
               l_in      = q_job.high_half;
               r_in      = q_job.low_half;
               formed_in = q_job.well_formed;
               round_in  = '0;
               state_in  = S_MUL1;
            end
         end
         S_MUL1: begin
            prod_in  = mul_src * hkf_pkg::MIX_MUL;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            prod_in  = mul_src * hkf_pkg::MIX_MUL;
            state_in = S_MIX;
         end
         S_MIX: begin
            l_in = r_ff;
            r_in = l_ff ^ mix_out;
            if (round_ff == LAST_ROUND) begin
               state_in = S_HOLD;
            end else begin
               round_in = round_ff + 1'b1;
               state_in = S_MUL1;
            end
         end
         S_HOLD: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      if (load_rsp) begin
         rsp_in.well_formed = formed_ff;
         rsp_in.granted     = formed_ff && (l_ff == cfg.match_high) &&
                              (r_ff == cfg.match_low);
         rsp_in.cipher_high = l_ff;
         rsp_in.cipher_low  = r_ff;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      round_ff  <= round_in;
      l_ff      <= l_in;
      r_ff      <= r_in;
      prod_ff   <= prod_in;
      formed_ff <= formed_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_last_round_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MIX) && (round_ff == LAST_ROUND) |=> (state_ff == S_HOLD))
      else $error("fourth round did not finish into hold");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("result load lost");

endmodule

/* hdl/hex_key_feistel_checker_core.sv */
// Channel   Ports                               Moves
// req       req_valid/req_stall, req_payload    one key character per request
// rsp       rsp_valid/rsp_stall, rsp_payload    verdict and cipher halves per string
// csr       csr_valid/csr_ready, csr_index/data round keys and expected words
//
// Front takes one character per cycle unless the queue is full and pushes a job
// into the queue on the last character. Back runs four Feistel rounds on a
// shared 32x32 multiplier, each round in MUL1, MUL2, MIX, loaded in IDLE, held in HOLD.
// Strings coming faster than back stall req once QUEUE_DEPTH jobs are waiting.
// Reset is synchronous; string state clears, registers take their defaults.
// rsp holds in its output register, so back starts the next job under a stall.
module hex_key_feistel_checker_core #(
   parameter int unsigned QUEUE_DEPTH = hkf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  hkf_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output hkf_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hkf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [hkf_pkg::WORD_WIDTH-1:0]      csr_data
);

   hkf_pkg::cfg_type        cfg_ff, cfg_in;
   hkf_pkg::fifo_flags_type q_flags;
   hkf_pkg::job_type        push_job, pop_job;
   logic                    q_push, q_pop;

   // the user must make writes only while idle, which the block does not enforce; no handshake back-pressure is given
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hkf_pkg::CSR_ROUND_KEY_ONE:   cfg_in.round_key[0] = csr_data;
            hkf_pkg::CSR_ROUND_KEY_TWO:   cfg_in.round_key[1] = csr_data;
            hkf_pkg::CSR_ROUND_KEY_THREE: cfg_in.round_key[2] = csr_data;
            hkf_pkg::CSR_ROUND_KEY_FOUR:  cfg_in.round_key[3] = csr_data;
            hkf_pkg::CSR_MATCH_HIGH:      cfg_in.match_high   = csr_data;
            hkf_pkg::CSR_MATCH_LOW:       cfg_in.match_low    = csr_data;
            default:                      cfg_in = cfg_ff;   // unmapped, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.round_key[0] <= hkf_pkg::ROUND_KEY_ONE_RESET;
         cfg_ff.round_key[1] <= hkf_pkg::ROUND_KEY_TWO_RESET;
         cfg_ff.round_key[2] <= hkf_pkg::ROUND_KEY_THREE_RESET;
         cfg_ff.round_key[3] <= hkf_pkg::ROUND_KEY_FOUR_RESET;
         cfg_ff.match_high   <= hkf_pkg::MATCH_HIGH_RESET;
         cfg_ff.match_low    <= hkf_pkg::MATCH_LOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // character accumulation, hex check and length count
   hkf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_flags     (q_flags),
      .q_push      (q_push),
      .q_job       (push_job)
   );

   // finished strings waiting for the round engine
   hkf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_job),
      .pop       (q_pop),
      .pop_data  (pop_job),
      .flags     (q_flags)
   );

   // Feistel rounds, compare, output register
   hkf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_flags     (q_flags),
      .q_job       (pop_job),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
